>>> rtl/core/fsgs_pkg.sv
// Package for the falling-sand grid block: grid geometry, cell codes, command codes,
// controller states and the command and status bundles between controller and datapath.
// Depends on nothing; every other file of the block but fsgs_ram imports it.
package fsgs_pkg;

  // Grid geometry.
  localparam int unsigned ROWS   = 32;
  localparam int unsigned COLS   = 64;
  localparam int unsigned CELLS  = ROWS * COLS;
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned COL_W  = $clog2(COLS);
  localparam int unsigned ADDR_W = $clog2(CELLS);

  // Payload widths of the two channels.
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IN_ROW_W   = 5;
  localparam int unsigned IN_COL_W   = 6;
  localparam int unsigned CODE_W     = 8;

  // Cell codes.
  localparam logic [CODE_W-1:0] CELL_AIR    = 8'h20;
  localparam logic [CODE_W-1:0] CELL_SAND   = 8'h23;
  localparam logic [CODE_W-1:0] CELL_WATER  = 8'h7E;
  localparam logic [CODE_W-1:0] CELL_CEMENT = 8'h40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PLACE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Neighbour tried for a move, in order of preference.
  typedef enum logic [2:0] {
    TR_DOWN       = 3'd0,
    TR_DOWN_LEFT  = 3'd1,
    TR_DOWN_RIGHT = 3'd2,
    TR_LEFT       = 3'd3,
    TR_RIGHT      = 3'd4
  } trial_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLACE,
    ST_READ,
    ST_COPY_IN,
    ST_COPY_IN_END,
    ST_FETCH,
    ST_KIND,
    ST_PROBE,
    ST_TEST,
    ST_SWAP_B,
    ST_SWAP_C,
    ST_SWAP_D,
    ST_COPY_OUT,
    ST_COPY_OUT_END,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic req_load;
    logic cnt_clr;
    logic cnt_inc;
    logic clear_wr;
    logic place_wr;
    logic read_rd;
    logic copy_in_rd;
    logic copy_in_wr;
    logic copy_out_rd;
    logic copy_out_wr;
    logic scan_clr;
    logic here_rd;
    logic kind_load;
    logic trial_inc;
    logic probe_rd;
    logic swap_here_rd;
    logic swap_tgt_rd;
    logic hold_load;
    logic swap_here_wr;
    logic swap_tgt_wr;
    logic advance;
    logic res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_last;
    logic is_mobile;
    logic trial_ok;
    logic trial_end;
    logic enter_ok;
    logic scan_last;
    logic out_busy;
  } dp_status_t;

  // Linear address of a cell, row-major.
  function automatic logic [ADDR_W-1:0] cell_addr(input int unsigned r, input int unsigned c);
    return ADDR_W'(r * COLS + c);
  endfunction

endpackage

>>> rtl/core/fsgs_if.sv
// Handshake channels of the falling-sand grid block: request and response.
// Depends on fsgs_pkg for the payload widths.
interface fsgs_req_if;
  import fsgs_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [IN_ROW_W-1:0] row;
  logic [IN_COL_W-1:0] col;
  logic [CODE_W-1:0]   cell_code;

  modport source (output valid, output command, output row, output col, output cell_code,
                  input ready);
  modport sink   (input valid, input command, input row, input col, input cell_code,
                  output ready);
endinterface

interface fsgs_rsp_if;
  import fsgs_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] cell_value;
  logic              done_res;

  modport source (output valid, output cell_value, output done_res, input ready);
  modport sink   (input valid, input cell_value, input done_res, output ready);
endinterface

>>> rtl/core/fsgs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module fsgs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule

>>> rtl/core/fsgs_ctrl.sv
// Controller of the falling-sand grid block: sequences clearing, commands and the step.
// Depends on fsgs_pkg; drives fsgs_dp through ctrl_cmd_t and reads dp_status_t.
module fsgs_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  input  logic [fsgs_pkg::CMD_W-1:0] req_command_i,
  output logic                     req_ready_o,
  output fsgs_pkg::ctrl_cmd_t      cmd_o,
  input  fsgs_pkg::dp_status_t     status_i
);
  import fsgs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.req_load = 1'b1;
          unique case (cmd_e'(req_command_i))
            CMD_PLACE: state_d = ST_PLACE;
            CMD_STEP:  state_d = ST_COPY_IN;
            CMD_READ:  state_d = ST_READ;
            CMD_NONE:  state_d = ST_RESULT;
          endcase
        end
      end
      ST_PLACE: begin
        cmd_o.place_wr = 1'b1;
        state_d        = ST_RESULT;
      end
      ST_READ: begin
        cmd_o.read_rd = 1'b1;
        state_d       = ST_RESULT;
      end
      ST_COPY_IN: begin
        cmd_o.copy_in_rd = 1'b1;
        cmd_o.copy_in_wr = !status_i.cnt_zero;
        if (status_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_COPY_IN_END;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_COPY_IN_END: begin
        cmd_o.copy_in_wr = 1'b1;
        cmd_o.scan_clr   = 1'b1;
        state_d          = ST_FETCH;
      end
      ST_FETCH: begin
        cmd_o.here_rd = 1'b1;
        state_d       = ST_KIND;
      end
      ST_KIND: begin
        cmd_o.kind_load = 1'b1;
        if (status_i.is_mobile) begin
          state_d = ST_PROBE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = status_i.scan_last ? ST_COPY_OUT : ST_FETCH;
        end
      end
      ST_PROBE: begin
        priority if (status_i.trial_ok) begin
          cmd_o.probe_rd = 1'b1;
          state_d        = ST_TEST;
        end else if (status_i.trial_end) begin
          cmd_o.advance = 1'b1;
          state_d       = status_i.scan_last ? ST_COPY_OUT : ST_FETCH;
        end else begin
          cmd_o.trial_inc = 1'b1;
        end
      end
      ST_TEST: begin
        priority if (status_i.enter_ok) begin
          cmd_o.swap_here_rd = 1'b1;
          state_d            = ST_SWAP_B;
        end else if (status_i.trial_end) begin
          cmd_o.advance = 1'b1;
          state_d       = status_i.scan_last ? ST_COPY_OUT : ST_FETCH;
        end else begin
          cmd_o.trial_inc = 1'b1;
          state_d         = ST_PROBE;
        end
      end
      ST_SWAP_B: begin
        cmd_o.swap_tgt_rd = 1'b1;
        cmd_o.hold_load   = 1'b1;
        state_d           = ST_SWAP_C;
      end
      ST_SWAP_C: begin
        cmd_o.swap_here_wr = 1'b1;
        state_d            = ST_SWAP_D;
      end
      ST_SWAP_D: begin
        cmd_o.swap_tgt_wr = 1'b1;
        cmd_o.advance     = 1'b1;
        state_d           = status_i.scan_last ? ST_COPY_OUT : ST_FETCH;
      end
      ST_COPY_OUT: begin
        cmd_o.copy_out_rd = 1'b1;
        cmd_o.copy_out_wr = !status_i.cnt_zero;
        if (status_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_COPY_OUT_END;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_COPY_OUT_END: begin
        cmd_o.copy_out_wr = 1'b1;
        state_d           = ST_RESULT;
      end
      ST_RESULT: begin
        if (!status_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
    endcase
  end
endmodule

>>> rtl/core/fsgs_dp.sv
// Datapath of the falling-sand grid block: grid and work RAMs, counters, neighbour
// addressing, move tests and the response register. Depends on fsgs_pkg and fsgs_ram.
module fsgs_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fsgs_pkg::ctrl_cmd_t          cmd_i,
  output fsgs_pkg::dp_status_t         status_o,
  input  logic [fsgs_pkg::CMD_W-1:0]    req_command_i,
  input  logic [fsgs_pkg::IN_ROW_W-1:0] req_row_i,
  input  logic [fsgs_pkg::IN_COL_W-1:0] req_col_i,
  input  logic [fsgs_pkg::CODE_W-1:0]   req_code_i,
  input  logic                         rsp_ready_i,
  output logic                         rsp_valid_o,
  output logic [fsgs_pkg::CODE_W-1:0]   rsp_value_o,
  output logic                         rsp_done_o
);
  import fsgs_pkg::*;

  // Latched request.
  cmd_e              req_cmd_q;
  logic              req_inside_q;
  logic [ADDR_W-1:0] req_addr_q;
  logic [CODE_W-1:0] req_code_q;

  // Sweep counter for clearing and copying, and the pending copy address.
  logic [ADDR_W-1:0] cnt_q;
  logic [ADDR_W-1:0] cp_addr_q;

  // Scan position, candidate move and particle kind.
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  trial_e            trial_q;
  logic              sand_q;
  logic [CODE_W-1:0] hold_q;

  // Response register.
  logic              rsp_valid_q;
  logic [CODE_W-1:0] rsp_value_q;
  logic              rsp_done_q;

  // RAM ports.
  logic              g_we, g_re, w_we, w_re;
  logic [ADDR_W-1:0] g_wa, g_ra, w_wa, w_ra;
  logic [CODE_W-1:0] g_wd, w_wd, g_rd, w_rd;

  logic [ADDR_W-1:0] here_addr, tgt_addr;
  logic              row_last, col_first, col_last;
  logic              geom_ok, trial_end;
  int unsigned       tr, tc;

  assign row_last  = (row_q == ROW_W'(ROWS - 1));
  assign col_first = (col_q == '0);
  assign col_last  = (col_q == COL_W'(COLS - 1));
  assign here_addr = cell_addr(int'(row_q), int'(col_q));

  always_comb begin
    tr        = int'(row_q);
    tc        = int'(col_q);
    geom_ok   = 1'b0;
    trial_end = 1'b1;
    unique case (trial_q)
      TR_DOWN: begin
        tr        = int'(row_q) + 1;
        geom_ok   = !row_last;
        trial_end = 1'b0;
      end
      TR_DOWN_LEFT: begin
        tr        = int'(row_q) + 1;
        tc        = int'(col_q) - 1;
        geom_ok   = !row_last && !col_first;
        trial_end = 1'b0;
      end
      TR_DOWN_RIGHT: begin
        tr        = int'(row_q) + 1;
        tc        = int'(col_q) + 1;
        geom_ok   = !row_last && !col_last;
        trial_end = sand_q;
      end
      TR_LEFT: begin
        tc        = int'(col_q) - 1;
        geom_ok   = !col_first && !sand_q;
        trial_end = 1'b0;
      end
      TR_RIGHT: begin
        tc        = int'(col_q) + 1;
        geom_ok   = !col_last && !sand_q;
        trial_end = 1'b1;
      end
      default: begin
        geom_ok   = 1'b0;
        trial_end = 1'b1;
      end
    endcase
  end

  assign tgt_addr = cell_addr(tr, tc);

  // Grid RAM port selection.
  always_comb begin
    g_we = 1'b0;
    g_wa = cnt_q;
    g_wd = CELL_AIR;
    g_re = 1'b0;
    g_ra = cnt_q;
    if (cmd_i.clear_wr) begin
      g_we = 1'b1;
    end
    if (cmd_i.place_wr) begin
      g_we = req_inside_q;
      g_wa = req_addr_q;
      g_wd = req_code_q;
    end
    if (cmd_i.copy_out_wr) begin
      g_we = 1'b1;
      g_wa = cp_addr_q;
      g_wd = w_rd;
    end
    if (cmd_i.read_rd) begin
      g_re = 1'b1;
      g_ra = req_addr_q;
    end
    if (cmd_i.copy_in_rd) begin
      g_re = 1'b1;
    end
    if (cmd_i.here_rd) begin
      g_re = 1'b1;
      g_ra = here_addr;
    end
    if (cmd_i.probe_rd) begin
      g_re = 1'b1;
      g_ra = tgt_addr;
    end
  end

  // Work RAM port selection.
  always_comb begin
    w_we = 1'b0;
    w_wa = cp_addr_q;
    w_wd = g_rd;
    w_re = 1'b0;
    w_ra = cnt_q;
    if (cmd_i.copy_in_wr) begin
      w_we = 1'b1;
    end
    if (cmd_i.swap_here_wr) begin
      w_we = 1'b1;
      w_wa = here_addr;
      w_wd = w_rd;
    end
    if (cmd_i.swap_tgt_wr) begin
      w_we = 1'b1;
      w_wa = tgt_addr;
      w_wd = hold_q;
    end
    if (cmd_i.copy_out_rd) begin
      w_re = 1'b1;
    end
    if (cmd_i.swap_here_rd) begin
      w_re = 1'b1;
      w_ra = here_addr;
    end
    if (cmd_i.swap_tgt_rd) begin
      w_re = 1'b1;
      w_ra = tgt_addr;
    end
  end

  fsgs_ram #(.WIDTH(CODE_W), .DEPTH(CELLS)) u_grid_ram (
    .clk_i     (clk_i),
    .wr_en_i   (g_we),
    .wr_addr_i (g_wa),
    .wr_data_i (g_wd),
    .rd_en_i   (g_re),
    .rd_addr_i (g_ra),
    .rd_data_o (g_rd)
  );

  fsgs_ram #(.WIDTH(CODE_W), .DEPTH(CELLS)) u_work_ram (
    .clk_i     (clk_i),
    .wr_en_i   (w_we),
    .wr_addr_i (w_wa),
    .wr_data_i (w_wd),
    .rd_en_i   (w_re),
    .rd_addr_i (w_ra),
    .rd_data_o (w_rd)
  );

  // Request payload, copy address, particle kind, held cell and response value.
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_cmd_q    <= cmd_e'(req_command_i);
      req_inside_q <= (int'(req_row_i) < ROWS) && (int'(req_col_i) < COLS);
      req_addr_q   <= cell_addr(int'(req_row_i), int'(req_col_i));
      req_code_q   <= req_code_i;
    end
    if (cmd_i.copy_in_rd || cmd_i.copy_out_rd) begin
      cp_addr_q <= cnt_q;
    end
    if (cmd_i.kind_load) begin
      sand_q <= (g_rd == CELL_SAND);
    end
    if (cmd_i.hold_load) begin
      hold_q <= w_rd;
    end
    if (cmd_i.res_load) begin
      rsp_value_q <= (req_cmd_q == CMD_READ && req_inside_q) ? g_rd : '0;
      rsp_done_q  <= (req_cmd_q != CMD_NONE);
    end
  end

  // Counters and response valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      trial_q     <= TR_DOWN;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + ADDR_W'(1);
      end

      if (cmd_i.scan_clr) begin
        row_q   <= '0;
        col_q   <= '0;
        trial_q <= TR_DOWN;
      end else if (cmd_i.advance) begin
        trial_q <= TR_DOWN;
        if (col_last) begin
          col_q <= '0;
          row_q <= row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end else if (cmd_i.trial_inc) begin
        trial_q <= trial_e'(trial_q + 3'd1);
      end

      if (cmd_i.res_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o.cnt_zero  = (cnt_q == '0);
    status_o.cnt_last  = (cnt_q == ADDR_W'(CELLS - 1));
    status_o.is_mobile = (g_rd == CELL_SAND) || (g_rd == CELL_WATER);
    status_o.trial_ok  = geom_ok;
    status_o.trial_end = trial_end;
    status_o.enter_ok  = sand_q ? ((g_rd != CELL_CEMENT) && (g_rd != CELL_SAND))
                                : (g_rd == CELL_AIR);
    status_o.scan_last = row_last && col_last;
    status_o.out_busy  = rsp_valid_q && !rsp_ready_i;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_value_o = rsp_value_q;
  assign rsp_done_o  = rsp_done_q;
endmodule

>>> rtl/core/falling_sand_grid_step.sv
// Top level of the falling-sand grid block: joins controller and datapath to the channels.
// Depends on fsgs_pkg, fsgs_if, fsgs_ctrl and fsgs_dp.
//
// The block keeps a 32 by 64 grid of 8-bit cell codes (space is air, '#' sand, '~' water,
// '@' cement, anything else is inert) and answers one command per request beat with
// exactly one response beat: place a code at a row and column, read a cell, or run one
// physics step. After reset the block first writes air into every cell, one cell a cycle,
// and accepts no request until every cell is clear. A place or read passes through its
// own state and then the result state, which loads the response register, and the block
// is ready for the next request as the response beat appears; the unused command code
// goes straight from idle to the result state. A step copies the grid into a work RAM,
// scans every cell in row-major order and copies the work RAM back; in the scan each cell
// is fetched and its kind checked, each neighbour position is either skipped at an edge
// or read and tested, and each move is carried out as a swap. Every access passes through
// the single read and single write port of each RAM. A new request is taken as soon as
// the block is idle, even while the previous response beat is still held in the output
// register; the result is then held back until the output register is free. Moves are
// decided on the grid as it stood before the step, and each move swaps two cells of the
// work RAM.
module falling_sand_grid_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  fsgs_req_if.sink    req_i,
  fsgs_rsp_if.source  rsp_o
);
  import fsgs_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // The controller owns the request handshake; the datapath owns the response register.
  fsgs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_command_i (req_i.command),
    .req_ready_o   (req_i.ready),
    .cmd_o         (ctrl_cmd),
    .status_i      (dp_status)
  );

  fsgs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .status_o      (dp_status),
    .req_command_i (req_i.command),
    .req_row_i     (req_i.row),
    .req_col_i     (req_i.col),
    .req_code_i    (req_i.cell_code),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_value_o   (rsp_o.cell_value),
    .rsp_done_o    (rsp_o.done_res)
  );
endmodule
